### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every rising clock edge outside reset.
`define URH_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define URH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/urh_pkg.sv
package urh_pkg;

    localparam int HISTORY_DEPTH_DEF = 128;
    localparam int VALUE_WIDTH_DEF   = 32;

    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int DATA_W  = 32;
    localparam int DEPTH_W = 8;

    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_EDIT = 2'd0;
    localparam op_t OP_UNDO = 2'd1;
    localparam op_t OP_REDO = 2'd2;

    typedef logic [ST_W-1:0] status_t;
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_NO_UNDO = 2'd1;
    localparam status_t ST_NO_REDO = 2'd2;
    localparam status_t ST_FULL    = 2'd3;

    // per-cycle command to one stack
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } stk_cmd_t;

    // one result transaction, first field highest
    typedef struct packed {
        logic [DEPTH_W-1:0] redo_depth;
        logic [DEPTH_W-1:0] undo_depth;
        status_t            status;
        logic [DATA_W-1:0]  current_value;
    } result_t;

endpackage

### hdl/urh_stack.sv
`include "assert_macros.svh"

// Bounded stack: top entry in a register, entry just below it prefetched
// from the RAM, so a push or pop can happen every cycle.
module urh_stack
    import urh_pkg::*;
#(
    parameter int DEPTH = HISTORY_DEPTH_DEF,
    parameter int VW    = VALUE_WIDTH_DEF,
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  stk_cmd_t      cmd,
    input  logic [VW-1:0] push_data,
    output logic [VW-1:0] top,
    output logic [CW-1:0] count,
    output logic [CW-1:0] count_next
);

    localparam int AW = $clog2(DEPTH);

    logic [VW-1:0] mem [DEPTH];
    logic [VW-1:0] top_reg;
    logic [VW-1:0] below_reg;
    logic [CW-1:0] count_reg;

    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;
    logic          wr_en;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = cmd.push && !full;
    assign do_pop  = cmd.pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (do_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // old top spills into the RAM on a push
    assign wr_en = do_push && !empty;
    assign waddr = AW'(count_reg - CW'(1));
    // prefetch the entry that sits below the new top
    assign raddr = AW'(count_next - CW'(2));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= top_reg;
        end
        if (wr_en && (waddr == raddr))
        begin
            below_reg <= top_reg;
        end
        else
        begin
            below_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            top_reg <= push_data;
        end
        else if (do_pop)
        begin
            top_reg <= below_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top   = top_reg;
    assign count = count_reg;

    `URH_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "stack count over depth")
    `URH_ASSERT_NEXT(a_clear_empties, clk, rst_n, cmd.clear, count_reg == '0, "clear left entries")

endmodule

### hdl/urh_outq.sv
`include "assert_macros.svh"

// Two-entry result queue between the history logic and the master port.
module urh_outq
    import urh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int QUEUE_DEPTH = 2;

    result_t    q_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       push;
    logic       pop;

    assign in_ready  = (fill_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (fill_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = q_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    `URH_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= 2'(QUEUE_DEPTH), "queue overfilled")
    `URH_ASSERT_ALWAYS(a_no_drop, clk, rst_n, !(in_valid && !in_ready), "result offered while full")

endmodule

### hdl/undo_redo_history.sv
// Undo/redo history: a current value plus two bounded stacks (undo, redo).
// Slave channel s_axis_*: one transaction per operation; tuser carries the
// operation (edit, undo, redo), tdata the new value used by an edit.
// Master channel m_axis_*: one transaction per operation with the current
// value and both stack depths in tdata and the status code in tuser.
// Each result is written into the result queue and offered on m_axis from
// there. Throughput: one operation per cycle while s_axis_tready is high;
// the rate is set by the stack top registers plus the prefetched below-top
// RAM read of each stack, which let a push or pop land on every operation.
// Results go through a two-entry queue, so an operation is still accepted
// while one result waits; s_axis_tready drops only when both entries are
// held by a stalled receiver and returns once m_axis_tready takes one.
// Reset (rst_n low, asynchronous) sets the current value to zero, empties
// both stacks and the result queue. Stack RAM contents are not cleared and
// are never used before being written. No clearing pass is needed.
// Full undo stack on edit: the old value is dropped, status reports it.
module undo_redo_history
    import urh_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] new_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] current_value, [39:32] undo_depth,
                                        // [47:40] redo_depth
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(HISTORY_DEPTH + 1);

    logic                   in_accept;
    op_t                    op;
    logic [63:0]            nv_wide;
    logic [VALUE_WIDTH-1:0] nv;

    logic [VALUE_WIDTH-1:0] cur_reg;
    logic [VALUE_WIDTH-1:0] cur_next;
    status_t                status;

    stk_cmd_t               undo_cmd;
    stk_cmd_t               redo_cmd;
    logic [VALUE_WIDTH-1:0] undo_top;
    logic [VALUE_WIDTH-1:0] redo_top;
    logic [CW-1:0]          undo_cnt;
    logic [CW-1:0]          redo_cnt;
    logic [CW-1:0]          undo_cnt_next;
    logic [CW-1:0]          redo_cnt_next;

    logic [63:0]            cur_wide;
    logic [15:0]            undo_ext;
    logic [15:0]            redo_ext;
    result_t                res;
    result_t                res_out;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign op        = s_axis_tuser;
    assign nv_wide   = 64'(s_axis_tdata);
    assign nv        = nv_wide[VALUE_WIDTH-1:0];

    // operation decode: each op is at most one push and one pop
    always_comb
    begin
        undo_cmd = '0;
        redo_cmd = '0;
        cur_next = cur_reg;
        status   = ST_OK;
        if (in_accept)
        begin
            unique case (op)
                OP_EDIT:
                begin
                    undo_cmd.push  = 1'b1;
                    redo_cmd.clear = 1'b1;
                    cur_next       = nv;
                    if (undo_cnt == CW'(HISTORY_DEPTH))
                    begin
                        status = ST_FULL;
                    end
                end
                OP_UNDO:
                begin
                    if (undo_cnt == '0)
                    begin
                        status = ST_NO_UNDO;
                    end
                    else
                    begin
                        redo_cmd.push = 1'b1;
                        undo_cmd.pop  = 1'b1;
                        cur_next      = undo_top;
                    end
                end
                OP_REDO:
                begin
                    if (redo_cnt == '0)
                    begin
                        status = ST_NO_REDO;
                    end
                    else
                    begin
                        undo_cmd.push = 1'b1;
                        redo_cmd.pop  = 1'b1;
                        cur_next      = redo_top;
                    end
                end
                default:
                begin
                    // unused code: no change, status ok
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
    end

    // both stacks push the current value
    urh_stack #(
        .DEPTH (HISTORY_DEPTH),
        .VW    (VALUE_WIDTH)
    ) u_undo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (undo_cmd),
        .push_data  (cur_reg),
        .top        (undo_top),
        .count      (undo_cnt),
        .count_next (undo_cnt_next)
    );

    urh_stack #(
        .DEPTH (HISTORY_DEPTH),
        .VW    (VALUE_WIDTH)
    ) u_redo (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (redo_cmd),
        .push_data  (cur_reg),
        .top        (redo_top),
        .count      (redo_cnt),
        .count_next (redo_cnt_next)
    );

    // result fields: value widened then cut to 32 bits, depths low 8 bits
    assign cur_wide = 64'(cur_next);
    assign undo_ext = 16'(undo_cnt_next);
    assign redo_ext = 16'(redo_cnt_next);

    always_comb
    begin
        res.current_value = cur_wide[DATA_W-1:0];
        res.status        = status;
        res.undo_depth    = undo_ext[DEPTH_W-1:0];
        res.redo_depth    = redo_ext[DEPTH_W-1:0];
    end

    urh_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept),
        .in_ready  (s_axis_tready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_out)
    );

    assign m_axis_tdata = {res_out.redo_depth, res_out.undo_depth, res_out.current_value};
    assign m_axis_tuser = res_out.status;

    // the two stacks together never hold more entries than the history depth
    `URH_ASSERT_ALWAYS(a_total_bound, clk, rst_n, (CW+1)'(undo_cnt) + (CW+1)'(redo_cnt) <= (CW+1)'(HISTORY_DEPTH), "history over depth")
    `URH_ASSERT_NEXT(a_edit_kills_redo, clk, rst_n, in_accept && (op == OP_EDIT), redo_cnt == '0, "redo kept after edit")

endmodule

### verif/testbench.sv
// Undo/redo history block, checked against a cycle-free predictor that
// keeps its own current value and the two history stacks.
module testbench;
    import urh_pkg::*;

    // Operation code three has no meaning; the block must ignore it.
    localparam op_t OP_UNUSED = 2'd3;
    localparam int  STACK_SIZE = HISTORY_DEPTH_DEF;
    localparam int  CYCLE_LIMIT = 200000;
    localparam int  DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] new_value
    logic [1:0]  s_axis_tuser = '0;     // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [31:0] current_value, [39:32] undo_depth,
                                        // [47:40] redo_depth
    logic [1:0]  m_axis_tuser;          // [1:0] status

    undo_redo_history uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: mirrors what the block should hold after every
    // accepted transaction.
    // ------------------------------------------------------------------
    logic [31:0] value_now;
    logic [31:0] undo_hist [STACK_SIZE];
    logic [31:0] redo_hist [STACK_SIZE];
    int          undo_cnt;
    int          redo_cnt;

    result_t     pending_results [$];   // expected results, oldest first
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Idle rates in percent, changed per phase by the stimulus.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    function automatic result_t apply_operation(op_t op, logic [31:0] value);
        result_t r;
        r.status = ST_OK;
        case (op)
            OP_EDIT:
            begin
                // a full undo stack drops the old value but the edit still lands
                if (undo_cnt < STACK_SIZE)
                begin
                    undo_hist[undo_cnt] = value_now;
                    undo_cnt++;
                end
                else
                begin
                    r.status = ST_FULL;
                end
                value_now = value;
                redo_cnt  = 0;
            end
            OP_UNDO:
            begin
                if (undo_cnt == 0)
                begin
                    r.status = ST_NO_UNDO;
                end
                else
                begin
                    if (redo_cnt < STACK_SIZE)
                    begin
                        redo_hist[redo_cnt] = value_now;
                        redo_cnt++;
                    end
                    undo_cnt--;
                    value_now = undo_hist[undo_cnt];
                end
            end
            OP_REDO:
            begin
                if (redo_cnt == 0)
                begin
                    r.status = ST_NO_REDO;
                end
                else
                begin
                    if (undo_cnt < STACK_SIZE)
                    begin
                        undo_hist[undo_cnt] = value_now;
                        undo_cnt++;
                    end
                    redo_cnt--;
                    value_now = redo_hist[redo_cnt];
                end
            end
            default:
            begin
                // unused code: nothing changes
            end
        endcase
        r.current_value = value_now;
        r.undo_depth    = undo_cnt[7:0];
        r.redo_depth    = redo_cnt[7:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Called right after a rising edge; tvalid is left high
    // after acceptance so a back-to-back transaction needs only one
    // assignment in that time step.
    // ------------------------------------------------------------------
    task automatic send_op(op_t op, logic [31:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(apply_operation(op, value));
    endtask

    // Holds the sender off until the block has returned every result.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random backpressure, one check per result transaction.
    // ------------------------------------------------------------------
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("undo_redo_history test failed");
            $finish;
        end
        else if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.current_value = m_axis_tdata[31:0];
            got.undo_depth    = m_axis_tdata[39:32];
            got.redo_depth    = m_axis_tdata[47:40];
            got.status        = m_axis_tuser;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result, value", got.current_value, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.current_value !== want.current_value)
                    report_mismatch("current_value", got.current_value, want.current_value);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.undo_depth !== want.undo_depth)
                    report_mismatch("undo_depth", 32'(got.undo_depth),
                                    32'(want.undo_depth));
                if (got.redo_depth !== want.redo_depth)
                    report_mismatch("redo_depth", 32'(got.redo_depth),
                                    32'(want.redo_depth));
            end
        end
    end

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Undo and redo straight out of reset, both stacks empty.
    task automatic test_empty_history();
        send_op(OP_UNDO, 32'hFFFF_FFFF);
        send_op(OP_REDO, 32'h0000_0000);
        send_op(OP_UNDO, 32'h1234_5678);
    endtask

    // Edits with extreme values, a full undo/redo round trip, and an edit
    // that discards pending redo entries.
    task automatic test_edit_undo_redo();
        send_op(OP_EDIT, 32'h0000_0000);
        send_op(OP_EDIT, 32'hFFFF_FFFF);
        send_op(OP_EDIT, 32'hA5A5_5A5A);
        send_op(OP_EDIT, 32'h8000_0001);
        send_op(OP_UNDO, 32'h0);
        send_op(OP_UNDO, 32'hFFFF_FFFF);
        send_op(OP_REDO, 32'h0);
        send_op(OP_UNDO, 32'h0);
        send_op(OP_UNDO, 32'h0);
        send_op(OP_UNDO, 32'h0);
        send_op(OP_UNDO, 32'h0);        // undo stack now empty
        send_op(OP_UNDO, 32'h0);
        send_op(OP_REDO, 32'h0);
        send_op(OP_REDO, 32'h0);
        send_op(OP_EDIT, 32'h5A5A_A5A5); // drops the remaining redo entries
        send_op(OP_REDO, 32'h0);
    endtask

    // Code three must leave everything alone, whatever tdata holds.
    task automatic test_unused_code();
        send_op(OP_UNUSED, 32'hFFFF_FFFF);
        send_op(OP_UNUSED, 32'h0000_0000);
        send_op(OP_UNDO, 32'h0);
    endtask

    // Fill the undo stack past its limit, then walk all the way back and
    // forward again, one step past each end.
    task automatic test_history_full();
        repeat (STACK_SIZE + 3)
            send_op(OP_EDIT, $urandom());
        repeat (STACK_SIZE + 1)
            send_op(OP_UNDO, $urandom());
        repeat (STACK_SIZE + 1)
            send_op(OP_REDO, $urandom());
    endtask

    // Random operations in runs, so the stacks climb deep and unwind.
    task automatic test_random_ops(int n_items);
        int sent;
        int run;
        int kind;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            run  = $urandom_range(1, (kind == 0) ? 60 : 12);
            repeat (run)
            begin
                op_t op;
                int  pick;
                pick = $urandom_range(0, 99);
                case (kind)
                    0, 1, 2: op = (pick < 85) ? OP_EDIT : OP_UNDO;
                    3, 4:    op = (pick < 85) ? OP_UNDO : OP_REDO;
                    5, 6:    op = (pick < 85) ? OP_REDO : OP_UNDO;
                    default:
                    begin
                        if (pick < 35)      op = OP_EDIT;
                        else if (pick < 65) op = OP_UNDO;
                        else if (pick < 95) op = OP_REDO;
                        else                op = OP_UNUSED;
                    end
                endcase
                send_op(op, $urandom());
                sent++;
            end
        end
    endtask

    initial
    begin
        value_now = '0;
        undo_cnt  = 0;
        redo_cnt  = 0;
        foreach (undo_hist[i]) undo_hist[i] = '0;
        foreach (redo_hist[i]) redo_hist[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase one: sender idles a little, receiver a lot
        send_idle_pct = 23;
        recv_idle_pct = 54;
        test_empty_history();
        test_edit_undo_redo();
        test_unused_code();
        wait_results_drained();
        test_history_full();
        test_random_ops(330);
        wait_results_drained();

        // phase two: the other way round
        send_idle_pct = 54;
        recv_idle_pct = 23;
        test_random_ops(330);
        wait_results_drained();

        // phase three: full throughput both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_ops(330);

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("undo_redo_history test passed");
        else
            $display("undo_redo_history test failed");
        $finish;
    end

endmodule
